/* rtl/uart_ring_buffer_fifos_assert.svh */
// Assertion macros for the ring buffer RTL, used by urb_ctrl.
// Users provide i_clk and i_rst_n in scope.
`ifndef UART_RING_BUFFER_FIFOS_ASSERT_SVH
`define UART_RING_BUFFER_FIFOS_ASSERT_SVH
// same-cycle implication
`define URB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define URB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/urb_pkg.sv */
// Types and opcodes for the UART ring buffer block.
// No dependencies.
package urb_pkg;

    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_GET  = 2'd1;
    localparam logic [1:0] OP_RECV = 2'd2;
    localparam logic [1:0] OP_XMIT = 2'd3;

    typedef struct packed {
        logic done;
        logic rd_rx;
        logic rd_tx;
        logic rx_avail;
        logic tx_room;
        logic rx_irq;
        logic tx_irq;
    } t_result;

endpackage

/* rtl/uart_ring_buffer_fifos.sv */
// UART ring buffers: one beat accepted per cycle, busy never asserted.
// Result strobes in the cycle after acceptance; the receiver cannot stall.
// Throughput: one beat per clock; each beat touches at most one memory word.
// Sync reset clears pointers, sets rx irq enable, clears tx irq enable.
// Byte stores are not cleared; unwritten entries are never read.
// Depends on urb_pkg, urb_ctrl and urb_ram.
module uart_ring_buffer_fifos #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_in,
    output logic       o_strobe,
    output logic [7:0] o_data_out,
    output logic       o_done_res,
    output logic       o_rx_available,
    output logic       o_tx_has_room,
    output logic       o_rx_irq_on,
    output logic       o_tx_irq_on
);

    localparam int AW = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;

    logic            tx_we, tx_re, rx_we, rx_re;
    logic [AW-1:0]   tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [7:0]      tx_rdata, rx_rdata;
    urb_pkg::t_result res;
    urb_pkg::t_result r_res;
    logic            r_strobe;

    urb_ctrl #(.AW(AW)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_opcode   (i_opcode),
        .o_tx_we    (tx_we),
        .o_tx_waddr (tx_waddr),
        .o_tx_re    (tx_re),
        .o_tx_raddr (tx_raddr),
        .o_rx_we    (rx_we),
        .o_rx_waddr (rx_waddr),
        .o_rx_re    (rx_re),
        .o_rx_raddr (rx_raddr),
        .o_res      (res)
    );

    urb_ram #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_data_in),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    urb_ram #(.DEPTH(BUFFER_DEPTH), .AW(AW)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (i_data_in),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= res;
    end

    assign busy           = 1'b0;
    assign o_strobe       = r_strobe;
    assign o_data_out     = r_res.rd_rx ? rx_rdata : (r_res.rd_tx ? tx_rdata : 8'd0);
    assign o_done_res     = r_res.done;
    assign o_rx_available = r_res.rx_avail;
    assign o_tx_has_room  = r_res.tx_room;
    assign o_rx_irq_on    = r_res.rx_irq;
    assign o_tx_irq_on    = r_res.tx_irq;

endmodule

/* rtl/urb_ram.sv */
// Byte store with one write port and one registered read port.
// No dependencies.
module urb_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/urb_ctrl.sv */
// Pointer and interrupt-enable control for the transmit and receive rings.
// Depends on urb_pkg and uart_ring_buffer_fifos_assert.svh.
`include "uart_ring_buffer_fifos_assert.svh"
module urb_ctrl #(
    parameter int AW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_opcode,
    output logic            o_tx_we,
    output logic [AW-1:0]   o_tx_waddr,
    output logic            o_tx_re,
    output logic [AW-1:0]   o_tx_raddr,
    output logic            o_rx_we,
    output logic [AW-1:0]   o_rx_waddr,
    output logic            o_rx_re,
    output logic [AW-1:0]   o_rx_raddr,
    output urb_pkg::t_result o_res
);

    logic [AW-1:0] r_tx_w, n_tx_w;
    logic [AW-1:0] r_tx_r, n_tx_r;
    logic [AW-1:0] r_rx_w, n_rx_w;
    logic [AW-1:0] r_rx_r, n_rx_r;
    logic          r_rx_irq, n_rx_irq;
    logic          r_tx_irq, n_tx_irq;
    logic          tx_room;
    logic          rx_room;
    logic          rx_nonempty;
    logic          tx_nonempty;
    urb_pkg::t_result res;

    assign tx_room     = (r_tx_w + AW'(1)) != r_tx_r;
    assign rx_room     = (r_rx_w + AW'(1)) != r_rx_r;
    assign rx_nonempty = r_rx_w != r_rx_r;
    assign tx_nonempty = r_tx_w != r_tx_r;

    always_comb begin
        n_tx_w   = r_tx_w;
        n_tx_r   = r_tx_r;
        n_rx_w   = r_rx_w;
        n_rx_r   = r_rx_r;
        n_rx_irq = r_rx_irq;
        n_tx_irq = r_tx_irq;
        o_tx_we  = 1'b0;
        o_tx_re  = 1'b0;
        o_rx_we  = 1'b0;
        o_rx_re  = 1'b0;
        res      = '0;
        if (i_start) begin
            case (i_opcode)
                urb_pkg::OP_PUT: begin
                    if (tx_room) begin
                        o_tx_we  = 1'b1;
                        n_tx_w   = r_tx_w + AW'(1);
                        n_tx_irq = 1'b1;
                        res.done = 1'b1;
                    end
                end
                urb_pkg::OP_GET: begin
                    if (rx_nonempty) begin
                        o_rx_re   = 1'b1;
                        n_rx_r    = r_rx_r + AW'(1);
                        res.done  = 1'b1;
                        res.rd_rx = 1'b1;
                    end
                end
                urb_pkg::OP_RECV: begin
                    if (r_rx_irq) begin
                        if (!rx_room) begin
                            n_rx_irq = 1'b0;
                        end else begin
                            o_rx_we  = 1'b1;
                            n_rx_w   = r_rx_w + AW'(1);
                            res.done = 1'b1;
                        end
                    end
                end
                urb_pkg::OP_XMIT: begin
                    if (r_tx_irq) begin
                        if (!tx_nonempty) begin
                            n_tx_irq = 1'b0;
                        end else begin
                            o_tx_re   = 1'b1;
                            n_tx_r    = r_tx_r + AW'(1);
                            res.done  = 1'b1;
                            res.rd_tx = 1'b1;
                        end
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
        end
        res.rx_avail = n_rx_w != n_rx_r;
        res.tx_room  = (n_tx_w + AW'(1)) != n_tx_r;
        res.rx_irq   = n_rx_irq;
        res.tx_irq   = n_tx_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_w   <= '0;
            r_tx_r   <= '0;
            r_rx_w   <= '0;
            r_rx_r   <= '0;
            r_rx_irq <= 1'b1;
            r_tx_irq <= 1'b0;
        end else begin
            r_tx_w   <= n_tx_w;
            r_tx_r   <= n_tx_r;
            r_rx_w   <= n_rx_w;
            r_rx_r   <= n_rx_r;
            r_rx_irq <= n_rx_irq;
            r_tx_irq <= n_tx_irq;
        end
    end

    assign o_tx_waddr = r_tx_w;
    assign o_tx_raddr = r_tx_r;
    assign o_rx_waddr = r_rx_w;
    assign o_rx_raddr = r_rx_r;
    assign o_res      = res;

    `URB_ASSERT_NEXT(a_rx_irq_sticky, !r_rx_irq, !r_rx_irq, "rx irq re-enabled without reset")
    `URB_ASSERT_IMPL(a_one_access, 1'b1,
        $countones({o_tx_we, o_tx_re, o_rx_we, o_rx_re}) <= 1, "several memory accesses per beat")
    `URB_ASSERT_NEXT(a_tx_wptr_hold, !(i_start && i_opcode == urb_pkg::OP_PUT),
        $stable(r_tx_w), "tx write pointer moved without a put")
    `URB_ASSERT_IMPL(a_done_needs_start, res.done, i_start, "done without an accepted beat")

endmodule

/* verif/tb_uart_ring_buffer_fifos.sv */
`timescale 1ns / 100ps
// Testbench for uart_ring_buffer_fifos: put, get, line receive and transmit-ready beats,
// each result strobe checked against an in-bench ring buffer tracker kept in a class.
// Depends on urb_pkg and the uart_ring_buffer_fifos RTL.
module tb_uart_ring_buffer_fifos;

    localparam int DEPTH       = 256;
    localparam int STALL_LIMIT = 1000;
    localparam int SEG_BEATS   = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       done;
        logic       rx_avail;
        logic       tx_room;
        logic       rx_irq;
        logic       tx_irq;
    } t_uart_status;

    class ring_buffer_tracker;
        logic [7:0]   tx_mem [DEPTH];
        logic [7:0]   rx_mem [DEPTH];
        logic [7:0]   tx_wr, tx_rd, rx_wr, rx_rd;
        logic         rx_irq, tx_irq;
        t_uart_status status_q[$];
        int           errors;

        function new();
            tx_wr  = 8'd0;
            tx_rd  = 8'd0;
            rx_wr  = 8'd0;
            rx_rd  = 8'd0;
            rx_irq = 1'b1;
            tx_irq = 1'b0;
            errors = 0;
        endfunction

        function int rx_level();
            logic [7:0] diff;
            diff = rx_wr - rx_rd;
            return int'(diff);
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void take_beat(logic [1:0] op, logic [7:0] din);
            t_uart_status s;
            logic [7:0]   nxt;
            s = '0;
            case (op)
                urb_pkg::OP_PUT: begin
                    nxt = tx_wr + 8'd1;
                    if (nxt != tx_rd) begin
                        tx_mem[tx_wr] = din;
                        tx_wr  = nxt;
                        tx_irq = 1'b1;
                        s.done = 1'b1;
                    end
                end
                urb_pkg::OP_GET: begin
                    if (rx_wr != rx_rd) begin
                        s.data = rx_mem[rx_rd];
                        rx_rd  = rx_rd + 8'd1;
                        s.done = 1'b1;
                    end
                end
                urb_pkg::OP_RECV: begin
                    if (rx_irq) begin
                        nxt = rx_wr + 8'd1;
                        if (nxt == rx_rd) begin
                            rx_irq = 1'b0;
                        end else begin
                            rx_mem[rx_wr] = din;
                            rx_wr  = nxt;
                            s.done = 1'b1;
                        end
                    end
                end
                urb_pkg::OP_XMIT: begin
                    if (tx_irq) begin
                        if (tx_wr == tx_rd) begin
                            tx_irq = 1'b0;
                        end else begin
                            s.data = tx_mem[tx_rd];
                            tx_rd  = tx_rd + 8'd1;
                            s.done = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            nxt        = tx_wr + 8'd1;
            s.rx_avail = (rx_wr != rx_rd);
            s.tx_room  = (nxt != tx_rd);
            s.rx_irq   = rx_irq;
            s.tx_irq   = tx_irq;
            status_q.push_back(s);
        endfunction

        function void check_status(t_uart_status got);
            t_uart_status want;
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result strobe with no beat outstanding", $realtime);
                return;
            end
            want = status_q.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp data=%h done=%b rxa=%b room=%b rxi=%b txi=%b",
                             $realtime, want.data, want.done, want.rx_avail, want.tx_room,
                             want.rx_irq, want.tx_irq,
                             " | got data=%h done=%b rxa=%b room=%b rxi=%b txi=%b",
                             got.data, got.done, got.rx_avail,
                             got.tx_room, got.rx_irq, got.tx_irq);
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] opcode;
    logic [7:0] data_in;
    logic       o_strobe;
    logic [7:0] o_data_out;
    logic       o_done_res;
    logic       o_rx_available;
    logic       o_tx_has_room;
    logic       o_rx_irq_on;
    logic       o_tx_irq_on;

    ring_buffer_tracker tracker = new();
    int idle_pct;
    int stall_cycles;

    uart_ring_buffer_fifos #(
        .BUFFER_DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (opcode),
        .i_data_in      (data_in),
        .o_strobe       (o_strobe),
        .o_data_out     (o_data_out),
        .o_done_res     (o_done_res),
        .o_rx_available (o_rx_available),
        .o_tx_has_room  (o_tx_has_room),
        .o_rx_irq_on    (o_rx_irq_on),
        .o_tx_irq_on    (o_tx_irq_on)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_uart_status seen;
        if (!i_rst_n) begin
            stall_cycles = 0;
        end else begin
            if (o_strobe) begin
                seen.data     = o_data_out;
                seen.done     = o_done_res;
                seen.rx_avail = o_rx_available;
                seen.tx_room  = o_tx_has_room;
                seen.rx_irq   = o_rx_irq_on;
                seen.tx_irq   = o_tx_irq_on;
                tracker.check_status(seen);
            end
            if (start && !busy)
                tracker.take_beat(opcode, data_in);
            if (o_strobe || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_uart_ring_buffer_fifos NOT OK");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] din);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        opcode  <= op;
        data_in <= din;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic random_beat();
        logic [1:0] op;
        op = 2'($urandom_range(3));
        if (op == urb_pkg::OP_RECV && tracker.rx_level() >= 200)
            op = urb_pkg::OP_GET;
        send_beat(op, 8'($urandom));
    endtask

    initial begin
        int         n;
        int         kind;
        int         count;
        logic [7:0] b;

        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        opcode   <= urb_pkg::OP_PUT;
        data_in  <= 8'h00;
        idle_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats
        send_beat(urb_pkg::OP_XMIT, 8'hFF);
        send_beat(urb_pkg::OP_GET,  8'hFF);
        send_beat(urb_pkg::OP_PUT,  8'h00);
        send_beat(urb_pkg::OP_PUT,  8'hFF);
        send_beat(urb_pkg::OP_PUT,  8'h80);
        repeat (3) send_beat(urb_pkg::OP_XMIT, 8'h00);
        send_beat(urb_pkg::OP_XMIT, 8'hA5);
        send_beat(urb_pkg::OP_XMIT, 8'h5A);
        send_beat(urb_pkg::OP_RECV, 8'h00);
        send_beat(urb_pkg::OP_RECV, 8'hFF);
        send_beat(urb_pkg::OP_RECV, 8'h01);
        repeat (3) send_beat(urb_pkg::OP_GET, 8'h00);
        send_beat(urb_pkg::OP_GET,  8'hAA);
        send_beat(urb_pkg::OP_PUT,  8'h7F);
        send_beat(urb_pkg::OP_XMIT, 8'hFF);
        drain_results();

        // random segments, idle level rotates, drain between segments
        for (int seg = 0; seg < 6; seg++) begin
            case (seg % 3)
                0: idle_pct = 0;
                1: idle_pct = 75;
                default: idle_pct = 15;
            endcase
            if (seg == 2) begin
                // fill transmit side past full, then empty it
                repeat (DEPTH + 2) send_beat(urb_pkg::OP_PUT, 8'($urandom));
                repeat (DEPTH) send_beat(urb_pkg::OP_XMIT, 8'($urandom));
            end
            count = 0;
            while (count < SEG_BEATS) begin
                kind = $urandom_range(9);
                if (kind == 0) begin
                    n = $urandom_range(1, 16);
                    repeat (n) send_beat(urb_pkg::OP_PUT, 8'($urandom));
                    repeat (n + 1) send_beat(urb_pkg::OP_XMIT, 8'($urandom));
                    count += 2 * n + 1;
                end else if (kind == 1) begin
                    n = $urandom_range(1, 16);
                    if (n > 200 - tracker.rx_level())
                        n = 200 - tracker.rx_level();
                    repeat (n) send_beat(urb_pkg::OP_RECV, 8'($urandom));
                    repeat (n + 1) send_beat(urb_pkg::OP_GET, 8'($urandom));
                    count += 2 * n + 1;
                end else begin
                    random_beat();
                    count++;
                end
            end
            drain_results();
        end

        // fill receive side until a byte is dropped; receive stays off afterwards
        idle_pct = 15;
        while (tracker.rx_level() < DEPTH - 1) begin
            b = 8'($urandom);
            send_beat(urb_pkg::OP_RECV, b);
        end
        repeat (3) send_beat(urb_pkg::OP_RECV, 8'($urandom));
        repeat (60) random_beat();

        drain_results();
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb_uart_ring_buffer_fifos OK");
        end else begin
            $display("tb_uart_ring_buffer_fifos NOT OK");
        end
        $finish;
    end

endmodule
